// ===== rtl/core/complex_integer_alu_macros.svh =====
// Assertion macros used by the complex integer ALU top level.
`ifndef COMPLEX_INTEGER_ALU_MACROS_SVH
`define COMPLEX_INTEGER_ALU_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CIA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("complex_integer_alu: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("complex_integer_alu: next-cycle check failed");

`endif

// ===== rtl/core/cia_pkg.sv =====
// Types and constants of the complex integer ALU.
package cia_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
    localparam int MAG_WIDTH     = 2 * OPERAND_WIDTH + 1;
    localparam int RESULT_WIDTH  = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DIVZERO = 2'd1,
        ST_SAT     = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t                           opcode;
        logic signed [OPERAND_WIDTH-1:0]   first_real;
        logic signed [OPERAND_WIDTH-1:0]   first_imag;
        logic signed [OPERAND_WIDTH-1:0]   second_real;
        logic signed [OPERAND_WIDTH-1:0]   second_imag;
    } request_t;

    typedef struct packed {
        logic signed [RESULT_WIDTH-1:0] result_real;
        logic signed [RESULT_WIDTH-1:0] result_imag;
        status_t                        status;
    } response_t;

    typedef struct packed {
        logic valid;
        logic re_neg;
        logic im_neg;
        logic dz;
    } ctl_t;

endpackage

// ===== rtl/core/cia_front.sv =====
// Front end: products and sums in one stage, combine and sign/magnitude split in the next.
module cia_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  cia_pkg::request_t                   in_req,
    output cia_pkg::ctl_t                       ctl_out,
    output logic [cia_pkg::MAG_WIDTH-1:0]       re_mag_out,
    output logic [cia_pkg::MAG_WIDTH-1:0]       im_mag_out,
    output logic [cia_pkg::PROD_WIDTH-1:0]      den_out
);
    localparam int W  = cia_pkg::OPERAND_WIDTH;
    localparam int PW = cia_pkg::PROD_WIDTH;
    localparam int MW = cia_pkg::MAG_WIDTH;

    // stage 1 registers
    logic                     v1_reg;
    cia_pkg::opcode_t         op1_reg;
    logic signed [PW-1:0]     ac_reg, bd_reg, ad_reg, bc_reg;
    logic        [PW-1:0]     cc_reg, dd_reg;
    logic signed [W:0]        sre_reg, sim_reg;

    // stage 2 registers
    cia_pkg::ctl_t            ctl_reg;
    logic [MW-1:0]            re_mag_reg, im_mag_reg;
    logic [PW-1:0]            den_reg;

    logic signed [W:0]        a_x, b_x, c_x, d_x;
    logic signed [MW-1:0]     re_val, im_val;
    logic [PW-1:0]            den_sum;
    logic                     is_div;

    assign a_x = {in_req.first_real[W-1],  in_req.first_real};
    assign b_x = {in_req.first_imag[W-1],  in_req.first_imag};
    assign c_x = {in_req.second_real[W-1], in_req.second_real};
    assign d_x = {in_req.second_imag[W-1], in_req.second_imag};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg <= in_req.opcode;
            ac_reg  <= PW'(a_x) * PW'(c_x);
            bd_reg  <= PW'(b_x) * PW'(d_x);
            ad_reg  <= PW'(a_x) * PW'(d_x);
            bc_reg  <= PW'(b_x) * PW'(c_x);
            cc_reg  <= PW'(c_x) * PW'(c_x);
            dd_reg  <= PW'(d_x) * PW'(d_x);
            if (in_req.opcode == cia_pkg::OP_SUB) begin
                sre_reg <= a_x - c_x;
                sim_reg <= b_x - d_x;
            end else begin
                sre_reg <= a_x + c_x;
                sim_reg <= b_x + d_x;
            end
        end
    end

    assign is_div  = (op1_reg == cia_pkg::OP_DIV);
    assign den_sum = cc_reg + dd_reg;

    always_comb begin
        unique case (op1_reg)
            cia_pkg::OP_MUL: begin
                re_val = MW'(ac_reg) - MW'(bd_reg);
                im_val = MW'(ad_reg) + MW'(bc_reg);
            end
            cia_pkg::OP_DIV: begin
                re_val = MW'(ac_reg) + MW'(bd_reg);
                im_val = MW'(bc_reg) - MW'(ad_reg);
            end
            default: begin
                re_val = MW'(sre_reg);
                im_val = MW'(sim_reg);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg.valid <= v1_reg;
        end
        if (en) begin
            ctl_reg.re_neg <= re_val[MW-1];
            ctl_reg.im_neg <= im_val[MW-1];
            ctl_reg.dz     <= is_div && (den_sum == '0);
            re_mag_reg     <= re_val[MW-1] ? -re_val : re_val;
            im_mag_reg     <= im_val[MW-1] ? -im_val : im_val;
            // non-divide results pass the divider with a unit divisor
            den_reg        <= is_div ? den_sum : PW'(1);
        end
    end

    assign ctl_out    = ctl_reg;
    assign re_mag_out = re_mag_reg;
    assign im_mag_out = im_mag_reg;
    assign den_out    = den_reg;

endmodule

// ===== rtl/core/cia_div_step.sv =====
// One restoring-division step for both result parts, registered.
module cia_div_step (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  cia_pkg::ctl_t                   ctl_in,
    input  logic [cia_pkg::PROD_WIDTH-1:0]  den_in,
    input  logic [cia_pkg::MAG_WIDTH-1:0]   num_re_in,
    input  logic [cia_pkg::PROD_WIDTH-1:0]  rem_re_in,
    input  logic [cia_pkg::MAG_WIDTH-1:0]   num_im_in,
    input  logic [cia_pkg::PROD_WIDTH-1:0]  rem_im_in,
    output cia_pkg::ctl_t                   ctl_out,
    output logic [cia_pkg::PROD_WIDTH-1:0]  den_out,
    output logic [cia_pkg::MAG_WIDTH-1:0]   num_re_out,
    output logic [cia_pkg::PROD_WIDTH-1:0]  rem_re_out,
    output logic [cia_pkg::MAG_WIDTH-1:0]   num_im_out,
    output logic [cia_pkg::PROD_WIDTH-1:0]  rem_im_out
);
    localparam int PW = cia_pkg::PROD_WIDTH;
    localparam int MW = cia_pkg::MAG_WIDTH;

    cia_pkg::ctl_t   ctl_reg;
    logic [PW-1:0]   den_reg;
    logic [MW-1:0]   num_re_reg, num_im_reg;
    logic [PW-1:0]   rem_re_reg, rem_im_reg;

    logic [PW:0]     sh_re, sh_im, df_re, df_im;
    logic            q_re, q_im;

    // shift the next numerator bit in and subtract when it fits
    assign sh_re = {rem_re_in, num_re_in[MW-1]};
    assign sh_im = {rem_im_in, num_im_in[MW-1]};
    assign df_re = sh_re - {1'b0, den_in};
    assign df_im = sh_im - {1'b0, den_in};
    assign q_re  = (sh_re >= {1'b0, den_in});
    assign q_im  = (sh_im >= {1'b0, den_in});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg.valid <= ctl_in.valid;
        end
        if (en) begin
            ctl_reg.re_neg <= ctl_in.re_neg;
            ctl_reg.im_neg <= ctl_in.im_neg;
            ctl_reg.dz     <= ctl_in.dz;
            den_reg        <= den_in;
            num_re_reg     <= {num_re_in[MW-2:0], q_re};
            num_im_reg     <= {num_im_in[MW-2:0], q_im};
            rem_re_reg     <= q_re ? df_re[PW-1:0] : sh_re[PW-1:0];
            rem_im_reg     <= q_im ? df_im[PW-1:0] : sh_im[PW-1:0];
        end
    end

    assign ctl_out    = ctl_reg;
    assign den_out    = den_reg;
    assign num_re_out = num_re_reg;
    assign num_im_out = num_im_reg;
    assign rem_re_out = rem_re_reg;
    assign rem_im_out = rem_im_reg;

endmodule

// ===== rtl/core/complex_integer_alu.sv =====
// A request passes the front-end stages, the divider stages and the output register in turn.
// Throughput: one request per cycle while the output is not stalled; every operation walks the same pipeline.
// The divider has MAG_WIDTH stages, one quotient bit per stage.
// The whole pipeline holds while a result waits at the output and m_ready is low.
// Reset (aresetn, synchronous, active low) clears all valid bits; data is not cleared.
// Top level of the complex integer ALU.
`include "complex_integer_alu_macros.svh"

module complex_integer_alu (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cia_pkg::request_t     s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output cia_pkg::response_t    m_data
);
    localparam int PW = cia_pkg::PROD_WIDTH;
    localparam int MW = cia_pkg::MAG_WIDTH;
    localparam int RW = cia_pkg::RESULT_WIDTH;
    // wide enough for the quotient and for the 2^31 saturation bound
    localparam int XW = (MW > RW + 1) ? MW : RW + 1;

    // advance everything when the output register is free or being drained
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    cia_pkg::ctl_t   ctl_pipe    [0:MW];
    logic [PW-1:0]   den_pipe    [0:MW];
    logic [MW-1:0]   num_re_pipe [0:MW];
    logic [MW-1:0]   num_im_pipe [0:MW];
    logic [PW-1:0]   rem_re_pipe [0:MW];
    logic [PW-1:0]   rem_im_pipe [0:MW];

    // products, combine, sign/magnitude split
    cia_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .in_req     (s_data),
        .ctl_out    (ctl_pipe[0]),
        .re_mag_out (num_re_pipe[0]),
        .im_mag_out (num_im_pipe[0]),
        .den_out    (den_pipe[0])
    );

    assign rem_re_pipe[0] = '0;
    assign rem_im_pipe[0] = '0;

    // divider: one quotient bit per stage, most significant first
    for (genvar i = 0; i < MW; i++) begin : g_div
        cia_div_step u_step (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (en),
            .ctl_in     (ctl_pipe[i]),
            .den_in     (den_pipe[i]),
            .num_re_in  (num_re_pipe[i]),
            .rem_re_in  (rem_re_pipe[i]),
            .num_im_in  (num_im_pipe[i]),
            .rem_im_in  (rem_im_pipe[i]),
            .ctl_out    (ctl_pipe[i+1]),
            .den_out    (den_pipe[i+1]),
            .num_re_out (num_re_pipe[i+1]),
            .rem_re_out (rem_re_pipe[i+1]),
            .num_im_out (num_im_pipe[i+1]),
            .rem_im_out (rem_im_pipe[i+1])
        );
    end

    // saturate a sign/magnitude quotient to 32-bit two's complement
    function automatic logic [RW:0] sat32(input logic neg, input logic [MW-1:0] mag);
        logic [XW-1:0] mx;
        logic [XW-1:0] nx;
        mx = XW'(mag);
        nx = -mx;
        if (!neg) begin
            if (mx > XW'(32'h7FFF_FFFF)) begin
                sat32 = {1'b1, 32'h7FFF_FFFF};
            end else begin
                sat32 = {1'b0, mx[RW-1:0]};
            end
        end else begin
            if (mx > XW'(33'h0_8000_0000)) begin
                sat32 = {1'b1, 32'h8000_0000};
            end else begin
                sat32 = {1'b0, nx[RW-1:0]};
            end
        end
    endfunction

    logic [RW:0]           re_s, im_s;
    cia_pkg::ctl_t         last_ctl;
    logic                  m_valid_reg;
    cia_pkg::response_t    m_data_reg;

    assign last_ctl = ctl_pipe[MW];
    assign re_s     = sat32(last_ctl.re_neg, num_re_pipe[MW]);
    assign im_s     = sat32(last_ctl.im_neg, num_im_pipe[MW]);

    // output register: hold while the consumer stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= last_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (last_ctl.dz) begin
                m_data_reg.result_real <= '0;
                m_data_reg.result_imag <= '0;
                m_data_reg.status      <= cia_pkg::ST_DIVZERO;
            end else begin
                m_data_reg.result_real <= re_s[RW-1:0];
                m_data_reg.result_imag <= im_s[RW-1:0];
                m_data_reg.status      <= (re_s[RW] || im_s[RW]) ? cia_pkg::ST_SAT
                                                                 : cia_pkg::ST_OK;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a zero divisor always yields zero parts
    `CIA_ASSERT_NOW(a_dz_zero, aclk, aresetn, m_valid && (m_data.status == cia_pkg::ST_DIVZERO), (m_data.result_real == '0) && (m_data.result_imag == '0))
    // a stall freezes the head of the divider
    `CIA_ASSERT_NEXT(a_stall_hold, aclk, aresetn, !en, $stable(ctl_pipe[0].valid) && $stable(den_pipe[0]))
    // a stall freezes the tail of the divider
    `CIA_ASSERT_NEXT(a_tail_hold, aclk, aresetn, !en, $stable(last_ctl.valid) && $stable(num_re_pipe[MW]))

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the complex integer ALU: directed and random requests.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = cia_pkg::MAG_WIDTH + 3;
    localparam int STALL_LIMIT = 5000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    cia_pkg::request_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    cia_pkg::response_t m_data;

    // Expected responses, oldest first.
    cia_pkg::response_t expected_q[$];
    int        errors = 0;
    int        sent = 0;
    int        received = 0;
    int        quiet_cycles = 0;
    bit        hold_off = 1'b0;   // set to force the receiver into a long stall
    bit        rand_gaps = 1'b1;  // clear to send back to back

    always #5 aclk = ~aclk;

    complex_integer_alu DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clamp an exact 64-bit value to 32-bit signed; flag when clamped.
    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v,
                                                   inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Divide truncating toward zero.
    function automatic logic signed [63:0] div_trunc(input logic signed [63:0] num,
                                                     input logic signed [63:0] den);
        logic signed [63:0] mag;
        mag = (num < 0) ? -num : num;
        mag = mag / den;
        return (num < 0) ? -mag : mag;
    endfunction

    // Compute the complex result of one request.
    function automatic cia_pkg::response_t complex_result(input cia_pkg::request_t req);
        logic signed [63:0] a, b, c, d, re, im, den;
        bit sat;
        cia_pkg::response_t r;
        a = req.first_real;
        b = req.first_imag;
        c = req.second_real;
        d = req.second_imag;
        sat = 1'b0;
        case (req.opcode)
            cia_pkg::OP_ADD: begin re = a + c; im = b + d; end
            cia_pkg::OP_SUB: begin re = a - c; im = b - d; end
            cia_pkg::OP_MUL: begin re = a * c - b * d; im = a * d + b * c; end
            default: begin
                den = c * c + d * d;
                if (den == 0) begin
                    r.result_real = '0;
                    r.result_imag = '0;
                    r.status = cia_pkg::ST_DIVZERO;
                    return r;
                end
                re = div_trunc(a * c + b * d, den);
                im = div_trunc(b * c - a * d, den);
            end
        endcase
        r.result_real = clamp32(re, sat);
        r.result_imag = clamp32(im, sat);
        r.status = sat ? cia_pkg::ST_SAT : cia_pkg::ST_OK;
        return r;
    endfunction

    // Offer one request, after a random gap when rand_gaps is set; hold it until accepted.
    task automatic send_request(input cia_pkg::request_t req);
        int gap;
        gap = rand_gaps ? $urandom_range(0, 11) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_q.push_back(complex_result(req));
        sent++;
    endtask

    task automatic send_fields(input cia_pkg::opcode_t op, input logic [15:0] a,
                               input logic [15:0] b, input logic [15:0] c,
                               input logic [15:0] d);
        cia_pkg::request_t req;
        req.opcode = op;
        req.first_real = a;
        req.first_imag = b;
        req.second_real = c;
        req.second_imag = d;
        send_request(req);
    endtask

    function automatic logic [15:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // Drop valid and wait until every expected response has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    // Operand extremes under every operation, zero divisors and truncating divisions.
    task automatic test_directed();
        cia_pkg::opcode_t op;
        for (int k = 0; k < 4; k++) begin
            op = cia_pkg::opcode_t'(k);
            send_fields(op, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
            send_fields(op, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
            send_fields(op, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
            send_fields(op, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000);
        end
        // Zero divisor, with zero and nonzero dividends.
        send_fields(cia_pkg::OP_DIV, 16'h1234, 16'hFFFF, 16'h0000, 16'h0000);
        send_fields(cia_pkg::OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // Multiply with a real part near the positive limit; neither part saturates.
        send_fields(cia_pkg::OP_MUL, 16'h8000, 16'h7FFF, 16'h8000, 16'h8001);
        // Division with negative quotient parts truncates toward zero.
        send_fields(cia_pkg::OP_DIV, 16'hFFF9, 16'h0003, 16'h0002, 16'h0000);
        send_fields(cia_pkg::OP_DIV, 16'h0007, 16'hFFFB, 16'hFFFE, 16'h0001);
        drain();
    endtask

    task automatic test_random(input int count);
        cia_pkg::request_t req;
        repeat (count) begin
            req.opcode = cia_pkg::opcode_t'($urandom_range(0, 3));
            req.first_real = rand_operand();
            req.first_imag = rand_operand();
            // Small divisors keep division quotients interesting.
            if (req.opcode == cia_pkg::OP_DIV && $urandom_range(0, 2) == 0) begin
                req.second_real = 16'($signed($urandom_range(0, 6)) - 3);
                req.second_imag = 16'($signed($urandom_range(0, 6)) - 3);
            end else begin
                req.second_real = rand_operand();
                req.second_imag = rand_operand();
            end
            send_request(req);
        end
    endtask

    // Stall the output long enough to fill the pipeline while requests keep coming.
    task automatic test_backpressure();
        rand_gaps = 1'b0;
        hold_off = 1'b1;
        test_random(LATENCY + 20);
        rand_gaps = 1'b1;
        // Pause the sender until everything is back.
        drain();
    endtask

    // Receiver: random ready gaps, and a long hold-off counted here.
    initial begin
        int wait_cycles;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (3 * LATENCY) @(posedge aclk);
                hold_off = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            if (wait_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Compare each accepted response with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            received++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected response real=%0d imag=%0d status=%0d",
                         $time, m_data.result_real, m_data.result_imag, m_data.status);
                errors++;
            end else begin
                cia_pkg::response_t exp_r;
                exp_r = expected_q.pop_front();
                if (m_data.result_real !== exp_r.result_real) begin
                    $display("%0t: result_real expected %0d actual %0d",
                             $time, exp_r.result_real, m_data.result_real);
                    errors++;
                end
                if (m_data.result_imag !== exp_r.result_imag) begin
                    $display("%0t: result_imag expected %0d actual %0d",
                             $time, exp_r.result_imag, m_data.result_imag);
                    errors++;
                end
                if (m_data.status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, m_data.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing is accepted for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired with %0d responses pending",
                     $time, expected_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random(1280);
        drain();
        repeat (LATENCY + 10) @(posedge aclk);
        if (expected_q.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, expected_q.size());
            errors++;
        end
        $display("Sent %0d requests and checked %0d responses over all four operations,",
                 sent, received);
        $display("including zero divisors, saturation and a long output stall.");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
